### rtl/core/lmls_pkg.sv
// ----------------------------------------------------------------------------
// lmls_pkg
// Shared types and constants of the MAC learning switch: table geometry,
// field widths and the command and status bundles between top and sequencer.
// ----------------------------------------------------------------------------
package lmls_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int MAC_W         = 48;
  localparam int PORT_W        = 16;
  localparam int LEN_W         = 16;
  localparam int ETYPE_W       = 16;
  localparam int ENTRY_W       = MAC_W + PORT_W;
  localparam int MCAST_BIT     = 40;

  localparam logic [ETYPE_W-1:0] LLDP_TYPE = 16'h88CC;

  typedef logic [MAC_W-1:0]  mac_t;
  typedef logic [PORT_W-1:0] port_t;

  // Work requested from the table sequencer for one beat
  typedef struct packed {
    logic learn;
    logic lookup;
  } lmls_cmd_t;

  // Completion status returned by the table sequencer
  typedef struct packed {
    logic  done;
    logic  hit;
    port_t port;
  } lmls_res_t;

endpackage

### rtl/core/l2_mac_learning_switch.sv
// ----------------------------------------------------------------------------
// l2_mac_learning_switch
// Ethernet MAC learning bridge decision block: one forwarding decision per
// packet header summary, backed by a MAC/port table in a single-port RAM.
// ----------------------------------------------------------------------------
// An LLDP beat gives its result without touching the table; any other beat
//   scans up to F filled table entries for the learn pass and again for the
//   lookup pass, F the number after the learn pass (at most TABLE_ENTRIES),
//   the single RAM port reading one entry a cycle.
// One beat at a time: busy stays high from a non-LLDP beat until its result strobes.
// The receiver cannot stall: out_valid is high for exactly one cycle.
// Reset clears fill count, replace pointer and control; no RAM clearing pass.
// ----------------------------------------------------------------------------
module l2_mac_learning_switch (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_ingress_port,
  input  logic [47:0] in_source_mac,
  input  logic [47:0] in_dest_mac,
  input  logic [15:0] in_ether_type,
  input  logic        in_unbuffered,
  input  logic [15:0] in_total_length,
  input  logic [15:0] in_carried_length,
  // result channel
  output logic        out_valid,
  output logic        out_dropped,
  output logic        out_install_flow,
  output logic        out_send_packet,
  output logic        out_flood,
  output logic [15:0] out_egress_port,
  output logic        out_carry_data
);

  logic                  busy_r;
  logic                  ctrl_start_r;
  lmls_pkg::lmls_cmd_t   cmd_r;
  lmls_pkg::lmls_res_t   res;

  // latched beat payload, held stable while the sequencer works
  lmls_pkg::port_t       port_r;
  lmls_pkg::mac_t        src_r;
  lmls_pkg::mac_t        dst_r;
  logic                  unbuf_r;
  logic                  trunc_r;

  logic                  out_valid_r;
  logic                  out_dropped_r;
  logic                  out_install_r;
  logic                  out_send_r;
  logic                  out_flood_r;
  lmls_pkg::port_t       out_egress_r;
  logic                  out_carry_r;

  logic                  accept;
  logic                  is_lldp;
  logic                  send;

  assign accept  = start && !busy_r;
  assign is_lldp = (in_ether_type == lmls_pkg::LLDP_TYPE);

  // Forward when unknown or unbuffered; drop the packet-out if truncated
  assign send = (!res.hit || unbuf_r) && !trunc_r;

  lmls_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ctrl_start_r),
    .cmd     (cmd_r),
    .src_mac (src_r),
    .dst_mac (dst_r),
    .in_port (port_r),
    .res     (res)
  );

  // Control: busy, sequencer kick and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      ctrl_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ctrl_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      if (accept) begin
        if (is_lldp) begin
          // LLDP: answer at once, leave the table alone
          out_valid_r <= 1'b1;
        end else begin
          busy_r       <= 1'b1;
          ctrl_start_r <= 1'b1;
        end
      end else if (res.done) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end
    end
  end

  // Payload: capture beat fields and build the decision
  always_ff @(posedge clk) begin
    if (accept) begin
      port_r       <= in_ingress_port;
      src_r        <= in_source_mac;
      dst_r        <= in_dest_mac;
      unbuf_r      <= in_unbuffered;
      trunc_r      <= in_unbuffered && (in_total_length != in_carried_length);
      cmd_r.learn  <= !in_source_mac[lmls_pkg::MCAST_BIT];
      cmd_r.lookup <= !in_dest_mac[lmls_pkg::MCAST_BIT];
      if (is_lldp) begin
        out_dropped_r <= 1'b1;
        out_install_r <= 1'b0;
        out_send_r    <= 1'b0;
        out_flood_r   <= 1'b0;
        out_egress_r  <= '0;
        out_carry_r   <= 1'b0;
      end
    end else if (res.done) begin
      out_dropped_r <= 1'b0;
      out_install_r <= res.hit;
      out_send_r    <= send;
      out_flood_r   <= !res.hit;
      out_egress_r  <= res.port;
      out_carry_r   <= send && unbuf_r;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_dropped      = out_dropped_r;
  assign out_install_flow = out_install_r;
  assign out_send_packet  = out_send_r;
  assign out_flood        = out_flood_r;
  assign out_egress_port  = out_egress_r;
  assign out_carry_data   = out_carry_r;

  a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> busy_r)
    else $error("sequencer finished while block idle");

  a_kick_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_start_r |-> (busy_r && $past(accept)))
    else $error("sequencer started without an accepted beat");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && res.done) |=> (out_valid_r && !busy_r))
    else $error("completion not turned into a result");

endmodule

### rtl/core/lmls_ram.sv
// ----------------------------------------------------------------------------
// lmls_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lmls_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/lmls_ctrl.sv
// ----------------------------------------------------------------------------
// lmls_ctrl
// Table sequencer: scans the MAC table one entry a cycle to learn the source
// and then to look up the destination; owns fill count and replace pointer.
// ----------------------------------------------------------------------------
module lmls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lmls_pkg::lmls_cmd_t cmd,
  input  lmls_pkg::mac_t    src_mac,
  input  lmls_pkg::mac_t    dst_mac,
  input  lmls_pkg::port_t   in_port,
  output lmls_pkg::lmls_res_t res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WR
  } state_t;

  state_t                       state_r, state_nxt;
  logic [lmls_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [lmls_pkg::ADDR_W-1:0]  rp_r, rp_nxt;
  logic [lmls_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic                         pend_r, pend_nxt;
  logic [lmls_pkg::ADDR_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic                         lookup_mode_r, lookup_mode_nxt;
  logic                         lookup_pend_r, lookup_pend_nxt;
  logic [lmls_pkg::ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic                         done_r, done_nxt;
  logic                         hit_r, hit_nxt;
  lmls_pkg::port_t              port_r, port_nxt;

  logic                         mem_en, mem_we;
  logic [lmls_pkg::ADDR_W-1:0]  mem_addr;
  logic [lmls_pkg::ENTRY_W-1:0] mem_rdata;
  lmls_pkg::mac_t               key;
  logic                         match;
  logic                         more;
  logic                         full;

  lmls_ram #(
    .DEPTH (lmls_pkg::TABLE_ENTRIES),
    .WIDTH (lmls_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ({src_mac, in_port}),
    .rdata (mem_rdata)
  );

  assign key   = lookup_mode_r ? dst_mac : src_mac;
  assign match = pend_r && (mem_rdata[lmls_pkg::ENTRY_W-1:lmls_pkg::PORT_W] == key);
  assign more  = (idx_r < fill_r);
  assign full  = (fill_r == lmls_pkg::CNT_W'(lmls_pkg::TABLE_ENTRIES));

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    rp_nxt          = rp_r;
    idx_nxt         = idx_r;
    pend_nxt        = 1'b0;
    pend_idx_nxt    = pend_idx_r;
    lookup_mode_nxt = lookup_mode_r;
    lookup_pend_nxt = lookup_pend_r;
    wr_addr_nxt     = wr_addr_r;
    done_nxt        = 1'b0;
    hit_nxt         = hit_r;
    port_nxt        = port_r;
    mem_en          = 1'b0;
    mem_we          = 1'b0;
    mem_addr        = idx_r[lmls_pkg::ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          idx_nxt         = '0;
          hit_nxt         = 1'b0;
          port_nxt        = '0;
          lookup_pend_nxt = cmd.lookup;
          if (cmd.learn) begin
            lookup_mode_nxt = 1'b0;
            state_nxt       = ST_SCAN;
          end else if (cmd.lookup) begin
            lookup_mode_nxt = 1'b1;
            state_nxt       = ST_SCAN;
          end else begin
            done_nxt = 1'b1;
          end
        end
      end

      ST_SCAN: begin
        if (match || (!pend_r && !more)) begin
          // Scan ends: hit on the compared entry or all filled entries seen
          if (lookup_mode_r) begin
            hit_nxt   = match;
            port_nxt  = match ? mem_rdata[lmls_pkg::PORT_W-1:0] : '0;
            done_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            if (match) begin
              wr_addr_nxt = pend_idx_r;
            end else if (!full) begin
              wr_addr_nxt = fill_r[lmls_pkg::ADDR_W-1:0];
              fill_nxt    = fill_r + 1'b1;
            end else begin
              wr_addr_nxt = rp_r;
              rp_nxt      = (rp_r == lmls_pkg::ADDR_W'(lmls_pkg::TABLE_ENTRIES - 1)) ?
                            '0 : rp_r + 1'b1;
            end
            state_nxt = ST_WR;
          end
        end else if (more) begin
          // Issue the next read; compare it next cycle
          mem_en       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[lmls_pkg::ADDR_W-1:0];
          idx_nxt      = idx_r + 1'b1;
        end
      end

      ST_WR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = wr_addr_r;
        idx_nxt  = '0;
        if (lookup_pend_r) begin
          lookup_mode_nxt = 1'b1;
          state_nxt       = ST_SCAN;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      rp_r    <= '0;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rp_r    <= rp_nxt;
      pend_r  <= pend_nxt;
      done_r  <= done_nxt;
    end
    idx_r         <= idx_nxt;
    pend_idx_r    <= pend_idx_nxt;
    lookup_mode_r <= lookup_mode_nxt;
    lookup_pend_r <= lookup_pend_nxt;
    wr_addr_r     <= wr_addr_nxt;
    hit_r         <= hit_nxt;
    port_r        <= port_nxt;
  end

  assign res.done = done_r;
  assign res.hit  = hit_r;
  assign res.port = port_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lmls_pkg::CNT_W'(lmls_pkg::TABLE_ENTRIES))
    else $error("fill count beyond table depth");

  a_rp_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (rp_r != '0) |-> full)
    else $error("replace pointer moved before table filled");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, mem_addr} < {1'b0, fill_r}))
    else $error("write outside filled region");

endmodule

### tb/l2_mac_learning_switch_test.sv
// ----------------------------------------------------------------------------
// l2_mac_learning_switch_test
// Self-checking bench for the MAC learning switch: drives packet header
// beats through the start/busy command port, keeps its own copy of the
// station table to predict each forwarding decision, and compares every
// result strobe field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module l2_mac_learning_switch_test;
  import lmls_pkg::*;

  // One packet header summary, as presented on the command port
  typedef struct packed {
    port_t              ingress_port;
    mac_t               source_mac;
    mac_t               dest_mac;
    logic [ETYPE_W-1:0] ether_type;
    logic               unbuffered;
    logic [LEN_W-1:0]   total_length;
    logic [LEN_W-1:0]   carried_length;
  } pkt_hdr_t;

  // One forwarding decision, as strobed on the result port
  typedef struct packed {
    logic  dropped;
    logic  install_flow;
    logic  send_packet;
    logic  flood;
    port_t egress_port;
    logic  carry_data;
  } fwd_decision_t;

  localparam int POOL_MAX = 128;

  logic               clk               = 1'b0;
  logic               rst_n             = 1'b0;
  logic               start             = 1'b0;
  logic               busy;
  port_t              in_ingress_port   = '0;
  mac_t               in_source_mac     = '0;
  mac_t               in_dest_mac       = '0;
  logic [ETYPE_W-1:0] in_ether_type     = '0;
  logic               in_unbuffered     = 1'b0;
  logic [LEN_W-1:0]   in_total_length   = '0;
  logic [LEN_W-1:0]   in_carried_length = '0;
  logic               out_valid;
  logic               out_dropped;
  logic               out_install_flow;
  logic               out_send_packet;
  logic               out_flood;
  port_t              out_egress_port;
  logic               out_carry_data;

  // Shadow station table, mirrors what the block should have learned
  bit    station_valid [TABLE_ENTRIES];
  mac_t  station_mac   [TABLE_ENTRIES];
  port_t station_port  [TABLE_ENTRIES];
  int    evict_ptr = 0;

  fwd_decision_t expected_decisions[$];
  int            fail_count = 0;
  bit            sender_idles = 1'b1;

  // Host-side address pool for well-formed random traffic
  mac_t  pool_mac  [POOL_MAX];
  port_t pool_port [POOL_MAX];

  l2_mac_learning_switch dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_ingress_port   (in_ingress_port),
    .in_source_mac     (in_source_mac),
    .in_dest_mac       (in_dest_mac),
    .in_ether_type     (in_ether_type),
    .in_unbuffered     (in_unbuffered),
    .in_total_length   (in_total_length),
    .in_carried_length (in_carried_length),
    .out_valid         (out_valid),
    .out_dropped       (out_dropped),
    .out_install_flow  (out_install_flow),
    .out_send_packet   (out_send_packet),
    .out_flood         (out_flood),
    .out_egress_port   (out_egress_port),
    .out_carry_data    (out_carry_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Station table prediction
  // --------------------------------------------------------------------------

  // Return the first valid entry holding mac, or -1 when absent
  function automatic int find_station(mac_t mac);
    int slot;
    slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot < 0 && station_valid[i] && station_mac[i] == mac) slot = i;
    end
    return slot;
  endfunction

  // Update an existing entry, else take the lowest free one, else evict
  // round-robin and advance the eviction pointer.
  function automatic void learn_station(mac_t mac, port_t port);
    int slot;
    slot = find_station(mac);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot < 0 && !station_valid[i]) slot = i;
    end
    if (slot < 0) begin
      slot = evict_ptr;
      evict_ptr = (evict_ptr == TABLE_ENTRIES - 1) ? 0 : evict_ptr + 1;
    end
    station_valid[slot] = 1'b1;
    station_mac[slot]   = mac;
    station_port[slot]  = port;
  endfunction

  // Work out the decision for one accepted header and update the shadow table
  function automatic fwd_decision_t predict_decision(pkt_hdr_t hdr);
    fwd_decision_t d;
    int            slot;
    logic          hit;
    logic          send;
    d    = '0;
    slot = -1;
    // LLDP: drop and leave the table alone
    if (hdr.ether_type == LLDP_TYPE) begin
      d.dropped = 1'b1;
      return d;
    end
    // Learn first, so a frame sent to itself hits on its own ingress port
    if (!hdr.source_mac[MCAST_BIT]) learn_station(hdr.source_mac, hdr.ingress_port);
    // Multicast and broadcast destinations are never looked up
    if (!hdr.dest_mac[MCAST_BIT]) slot = find_station(hdr.dest_mac);
    hit  = (slot >= 0);
    send = !hit || hdr.unbuffered;
    // Truncated unbuffered packet: no packet-out at all
    if (hdr.unbuffered && hdr.total_length != hdr.carried_length) send = 1'b0;
    d.install_flow = hit;
    d.flood        = !hit;
    d.egress_port  = hit ? station_port[slot] : '0;
    d.send_packet  = send;
    d.carry_data   = send && hdr.unbuffered;
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: sample at the edge that ends the strobe cycle
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, logic [PORT_W-1:0] want,
                                      logic [PORT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    fwd_decision_t want;
    if (rst_n && out_valid) begin
      if (expected_decisions.size() == 0) begin
        $error("result beat with no decision pending");
        fail_count++;
      end else begin
        want = expected_decisions.pop_front();
        check_field("dropped",      PORT_W'(want.dropped),      PORT_W'(out_dropped));
        check_field("install_flow", PORT_W'(want.install_flow), PORT_W'(out_install_flow));
        check_field("send_packet",  PORT_W'(want.send_packet),  PORT_W'(out_send_packet));
        check_field("flood",        PORT_W'(want.flood),        PORT_W'(out_flood));
        check_field("egress_port",  want.egress_port,           out_egress_port);
        check_field("carry_data",   PORT_W'(want.carry_data),   PORT_W'(out_carry_data));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic pkt_hdr_t make_hdr(port_t port, mac_t src, mac_t dst,
                                        logic [ETYPE_W-1:0] etype, logic unbuf,
                                        logic [LEN_W-1:0] tot, logic [LEN_W-1:0] car);
    pkt_hdr_t h;
    h.ingress_port   = port;
    h.source_mac     = src;
    h.dest_mac       = dst;
    h.ether_type     = etype;
    h.unbuffered     = unbuf;
    h.total_length   = tot;
    h.carried_length = car;
    return h;
  endfunction

  function automatic mac_t random_mac();
    mac_t m;
    m[47:32] = 16'($urandom);
    m[31:0]  = $urandom;
    return m;
  endfunction

  function automatic mac_t random_unicast();
    mac_t m;
    m = random_mac();
    m[MCAST_BIT] = 1'b0;
    return m;
  endfunction

  // Present one header beat, hold it until the block takes it, then predict.
  // Start stays high on return; the next call raises it again or drops it.
  task automatic send_header(pkt_hdr_t hdr);
    int gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_ingress_port   <= hdr.ingress_port;
    in_source_mac     <= hdr.source_mac;
    in_dest_mac       <= hdr.dest_mac;
    in_ether_type     <= hdr.ether_type;
    in_unbuffered     <= hdr.unbuffered;
    in_total_length   <= hdr.total_length;
    in_carried_length <= hdr.carried_length;
    do @(posedge clk); while (busy);
    expected_decisions.push_back(predict_decision(hdr));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked headers: every decision path, field extremes, address corners
  task automatic test_directed();
    mac_t sta_a;
    mac_t sta_b;
    mac_t sta_c;
    mac_t sta_d;
    mac_t bcast;
    mac_t mcast;
    mac_t uni_ones;
    sta_a    = 48'h0000_1111_0001;
    sta_b    = 48'h02AA_BBCC_DD02;
    sta_c    = 48'h0000_2222_0003;
    sta_d    = 48'h0000_3333_0004;
    bcast    = 48'hFFFF_FFFF_FFFF;
    mcast    = 48'h0100_5E00_0001;
    uni_ones = 48'hFEFF_FFFF_FFFF;
    sender_idles = 1'b0;
    // LLDP with a unicast source: drop, must not learn sta_a
    send_header(make_hdr(16'hFFFF, sta_a, sta_b, LLDP_TYPE, 1'b1, 16'hFFFF, 16'h0000));
    // Miss on sta_a proves the LLDP beat learned nothing; buffered flood
    send_header(make_hdr(16'h0001, sta_c, sta_a, 16'h0800, 1'b0, 16'd64, 16'd64));
    // Learn sta_a on port 0, broadcast destination floods
    send_header(make_hdr(16'h0000, sta_a, bcast, 16'h0806, 1'b0, 16'd60, 16'd60));
    // Hit on a buffered packet: install only
    send_header(make_hdr(16'h0007, sta_b, sta_a, 16'h0800, 1'b0, 16'd100, 16'd100));
    // Hit on an unbuffered full-length packet: install and send with data
    send_header(make_hdr(16'h0009, sta_a, sta_b, 16'h86DD, 1'b1, 16'd1500, 16'd1500));
    // Truncated unbuffered hit: install, no packet-out
    send_header(make_hdr(16'h0009, sta_a, sta_b, 16'h86DD, 1'b1, 16'd1500, 16'd128));
    // Truncated unbuffered miss: flood flag set, still no packet-out
    send_header(make_hdr(16'h0009, sta_a, sta_d, 16'h0800, 1'b1, 16'd0, 16'hFFFF));
    // Unbuffered miss at full length: flood with data
    send_header(make_hdr(16'h0009, sta_a, sta_d, 16'h0800, 1'b1, 16'hFFFF, 16'hFFFF));
    // Same source and destination: hit on its own ingress port
    send_header(make_hdr(16'h1234, sta_d, sta_d, 16'h0800, 1'b0, 16'd0, 16'd0));
    // Station moves: update sta_a to a new port, then look it up
    send_header(make_hdr(16'hABCD, sta_a, sta_d, 16'h0800, 1'b0, 16'd64, 16'd64));
    send_header(make_hdr(16'h0002, sta_c, sta_a, 16'h0800, 1'b1, 16'd64, 16'd64));
    // Multicast source is not learned; multicast destination always floods
    send_header(make_hdr(16'h0005, mcast, sta_a, 16'h0800, 1'b0, 16'd64, 16'd64));
    send_header(make_hdr(16'h0006, sta_c, mcast, 16'h0800, 1'b0, 16'd64, 16'd64));
    // All-zero address is unicast
    send_header(make_hdr(16'h8000, 48'h0, sta_c, 16'h0000, 1'b0, 16'd0, 16'd0));
    send_header(make_hdr(16'h0003, sta_c, 48'h0, 16'hFFFF, 1'b1, 16'd0, 16'd0));
    // Highest unicast address: every bit set except the group bit
    send_header(make_hdr(16'hFFFF, uni_ones, uni_ones, 16'h88CD, 1'b1, 16'hFFFF, 16'hFFFF));
    // Broadcast as source and destination
    send_header(make_hdr(16'h0000, bcast, bcast, 16'h88CB, 1'b0, 16'hFFFF, 16'h0000));
    // LLDP with every other field at its top value
    send_header(make_hdr(16'hFFFF, bcast, bcast, LLDP_TYPE, 1'b1, 16'hFFFF, 16'hFFFF));
    // LLDP with everything else zero
    send_header(make_hdr(16'h0000, 48'h0, 48'h0, LLDP_TYPE, 1'b0, 16'h0000, 16'h0000));
    // Zero is still learned after the LLDP beats
    send_header(make_hdr(16'h5555, sta_b, 48'h0, 16'h0800, 1'b0, 16'd1, 16'd2));
    send_header(make_hdr(16'hAAAA, sta_c, uni_ones, 16'h0800, 1'b1, 16'd2, 16'd1));
  endtask

  // Overflow the table so round-robin eviction kicks in, then probe old
  // and new stations alike.
  task automatic test_table_overflow();
    mac_t learned [TABLE_ENTRIES + 26];
    int   n;
    sender_idles = 1'b1;
    n = TABLE_ENTRIES + 26;
    for (int i = 0; i < n; i++) begin
      learned[i] = random_unicast();
      send_header(make_hdr(port_t'($urandom), learned[i],
                           (i > 0) ? learned[$urandom_range(0, i - 1)] : 48'hFFFF_FFFF_FFFF,
                           16'h0800, 1'($urandom_range(0, 1)), 16'd64, 16'd64));
    end
    for (int i = 0; i < 40; i++) begin
      send_header(make_hdr(port_t'($urandom), learned[$urandom_range(0, n - 1)],
                           learned[$urandom_range(0, n - 1)], ETYPE_W'($urandom),
                           1'($urandom_range(0, 1)), 16'd128, 16'd128));
    end
  endtask

  // Phases of traffic over address pools of varying size: mostly well-formed
  // conversations between pool stations, plus LLDP, group addresses and
  // fully random headers.
  task automatic test_random_traffic();
    int       pool_sizes [8] = '{4, 16, 40, 63, 64, 65, 90, 128};
    int       pool_n;
    int       pick;
    int       roll;
    pkt_hdr_t h;
    for (int phase = 0; phase < 10; phase++) begin
      pool_n = pool_sizes[$urandom_range(0, 7)];
      // Alternate phases with and without sender gaps
      sender_idles = phase[0];
      for (int i = 0; i < pool_n; i++) begin
        pool_mac[i]  = random_unicast();
        pool_port[i] = port_t'($urandom);
      end
      for (int k = 0; k < 138; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 7) begin
          // Pure noise
          h = make_hdr(port_t'($urandom), random_mac(), random_mac(), ETYPE_W'($urandom),
                       1'($urandom_range(0, 1)), LEN_W'($urandom), LEN_W'($urandom));
        end else begin
          pick = $urandom_range(0, pool_n - 1);
          h = make_hdr(($urandom_range(0, 99) < 80) ? pool_port[pick] : port_t'($urandom),
                       pool_mac[pick], pool_mac[$urandom_range(0, pool_n - 1)],
                       ETYPE_W'($urandom), 1'($urandom_range(0, 1)), LEN_W'($urandom),
                       16'h0);
          h.carried_length = ($urandom_range(0, 99) < 75) ? h.total_length
                                                           : LEN_W'($urandom);
          if (roll < 15) h.ether_type = LLDP_TYPE;
          else if (roll < 20) h.source_mac = random_mac() | mac_t'(1) << MCAST_BIT;
          else if (roll < 25) h.dest_mac = 48'hFFFF_FFFF_FFFF;
          else if (roll < 30) h.dest_mac = random_mac() | mac_t'(1) << MCAST_BIT;
          else if (roll < 35) h.dest_mac = h.source_mac;
          else if (roll < 42) h.dest_mac = random_unicast();
        end
        send_header(h);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    // Hold reset, then release on an edge
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_overflow();
    test_random_traffic();
    // Drop start once the last beat is taken
    start <= 1'b0;
    // Drain pending decisions, then watch for stray strobes
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (2 * TABLE_ENTRIES + 20) @(posedge clk);
    if (fail_count == 0 && expected_decisions.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: well over the slowest legal run of every beat
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### l2_mac_learning_switch.f
rtl/core/lmls_pkg.sv
rtl/core/lmls_ram.sv
rtl/core/lmls_ctrl.sv
rtl/core/l2_mac_learning_switch.sv
tb/l2_mac_learning_switch_test.sv
